@@ rtl/core/lru_pr_pkg.sv @@
package lru_pr_pkg;

  localparam int unsigned PageInW  = 16;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned FaultW   = 32;
  localparam int unsigned CfgW     = 4;
  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lru_pr_state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } lru_pr_cmd_t;

  typedef struct packed {
    logic out_free;
  } lru_pr_status_t;

endpackage

@@ rtl/core/lru_pr_ctrl.sv @@
module lru_pr_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  lru_pr_pkg::lru_pr_status_t status_i,
  output lru_pr_pkg::lru_pr_cmd_t    cmd_o
);
  import lru_pr_pkg::*;

  lru_pr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/lru_pr_dpath.sv @@
module lru_pr_dpath #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lru_pr_pkg::CfgW-1:0]           frames_in_use_i,
  input  logic [lru_pr_pkg::PageInW-1:0]        page_number_i,
  input  lru_pr_pkg::lru_pr_cmd_t               cmd_i,
  output lru_pr_pkg::lru_pr_status_t            status_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic                                  hit_o,
  output logic [lru_pr_pkg::SlotW-1:0]          frame_slot_o,
  output logic                                  evicted_valid_o,
  output logic [lru_pr_pkg::PageInW-1:0]        evicted_page_o,
  output logic [lru_pr_pkg::FaultW-1:0]         fault_total_o
);
  import lru_pr_pkg::*;

  localparam int unsigned RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);

  logic [CfgW-1:0]      cfg_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
  logic [FRAMES-1:0]    frame_valid_q;
  logic [RW-1:0]        rank_q [FRAMES];
  logic [CW-1:0]        filled_q;
  logic [FaultW-1:0]    fault_q;

  logic                 hit_q, empty_q;
  logic [RW-1:0]        slot_q;
  logic [PAGE_BITS-1:0] evp_q;

  logic                 out_valid_q, out_hit_q, out_ev_q;
  logic [SlotW-1:0]     out_slot_q;
  logic [PageInW-1:0]   out_evp_q;
  logic [FaultW-1:0]    out_fault_q;

  logic [PageInW+PAGE_BITS-1:0] page_in_ext;
  logic [PAGE_BITS+PageInW-1:0] evp_ext;
  logic [RW+SlotW-1:0]          slot_ext;

  logic [FRAMES-1:0] in_use;
  logic              match_found, empty_found;
  logic [RW-1:0]     match_idx, empty_idx, victim_idx, min_rank;
  logic [RW-1:0]     cur_rank;
  logic              touch_valid, ev_now;
  logic [FaultW-1:0] fault_nx;

  assign page_in_ext = {{PAGE_BITS{1'b0}}, page_number_i};
  assign evp_ext     = {{PageInW{1'b0}}, evp_q};
  assign slot_ext    = {{SlotW{1'b0}}, slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= frames_in_use_i;
    end
  end

  // frames past the configured count stay valid but are not searched
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      in_use[i] = (i == 0) || (i < int'(cfg_q));
    end
  end

  always_comb begin
    match_found = 1'b0;
    empty_found = 1'b0;
    match_idx   = '0;
    empty_idx   = '0;
    victim_idx  = '0;
    min_rank    = rank_q[0];
    for (int i = 0; i < FRAMES; i++) begin
      if (!match_found && in_use[i] && frame_valid_q[i] && frame_page_q[i] == page_q) begin
        match_found = 1'b1;
        match_idx   = RW'(i);
      end
      if (!empty_found && in_use[i] && !frame_valid_q[i]) begin
        empty_found = 1'b1;
        empty_idx   = RW'(i);
      end
    end
    for (int i = 1; i < FRAMES; i++) begin
      if (in_use[i] && rank_q[i] < min_rank) begin
        min_rank   = rank_q[i];
        victim_idx = RW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_in_ext[PAGE_BITS-1:0];
    end
    if (cmd_i.lookup) begin
      hit_q   <= match_found;
      empty_q <= empty_found;
      evp_q   <= frame_page_q[victim_idx];
      if (match_found) begin
        slot_q <= match_idx;
      end else if (empty_found) begin
        slot_q <= empty_idx;
      end else begin
        slot_q <= victim_idx;
      end
    end
  end

  assign cur_rank    = rank_q[slot_q];
  assign touch_valid = hit_q || !empty_q;
  assign ev_now      = !hit_q && !empty_q;
  assign fault_nx    = (!hit_q && fault_q != '1) ? fault_q + 1'b1 : fault_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit_q) begin
      frame_page_q[slot_q] <= page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      filled_q      <= '0;
      fault_q       <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      fault_q <= fault_nx;
      if (touch_valid) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_valid_q[i] && rank_q[i] > cur_rank) begin
            rank_q[i] <= rank_q[i] - 1'b1;
          end
        end
        rank_q[slot_q] <= RW'(filled_q - 1'b1);
      end else begin
        rank_q[slot_q]        <= RW'(filled_q);
        frame_valid_q[slot_q] <= 1'b1;
        filled_q              <= filled_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_q   <= hit_q;
      out_slot_q  <= slot_ext[SlotW-1:0];
      out_ev_q    <= ev_now;
      out_evp_q   <= ev_now ? evp_ext[PageInW-1:0] : '0;
      out_fault_q <= fault_nx;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign frame_slot_o    = out_slot_q;
  assign evicted_valid_o = out_ev_q;
  assign evicted_page_o  = out_evp_q;
  assign fault_total_o   = out_fault_q;

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(filled_q) <= FRAMES)
    else $error("fill count above frame count");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && hit_q |-> !ev_now && frame_valid_q[slot_q])
    else $error("hit on an empty frame or with eviction");

  a_fault_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !hit_q |=> out_valid_q && out_fault_q != '0)
    else $error("fault not counted");

endmodule

@@ rtl/core/lru_page_replacement_unit.sv @@
// LRU page replacement unit: one page reference per input transaction, one
// result per reference (hit, frame slot, evicted page and saturating fault
// count). Each reference passes through accept, lookup across the frames in
// use, and update of ranks and frame contents, in the controller sequence; the
// result sits in an output register so the next reference is accepted while
// it waits, and updating holds only while that register is full and stalled.
// frames_in_use is written through its own channel, always ready; values of 0
// act as 1 and values above FRAMES act as FRAMES.
module lru_page_replacement_unit #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lru_pr_pkg::CfgW-1:0]      frames_in_use_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lru_pr_pkg::PageInW-1:0]   page_number_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [lru_pr_pkg::SlotW-1:0]     frame_slot_o,
  output logic                             evicted_valid_o,
  output logic [lru_pr_pkg::PageInW-1:0]   evicted_page_o,
  output logic [lru_pr_pkg::FaultW-1:0]    fault_total_o
);
  import lru_pr_pkg::*;

  lru_pr_cmd_t    cmd;
  lru_pr_status_t status;

  assign cfg_ready_o = 1'b1;

  lru_pr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lru_pr_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .frames_in_use_i (frames_in_use_i),
    .page_number_i   (page_number_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .hit_o           (hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

endmodule

@@ bench/lru_page_replacement_unit_tb.sv @@
module lru_page_replacement_unit_tb;
  import lru_pr_pkg::*;

  localparam int unsigned NumFrames  = 8;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic                 hit;
    logic [SlotW-1:0]     slot;
    logic                 evicted_valid;
    logic [PageInW-1:0]   evicted_page;
    logic [FaultW-1:0]    faults;
  } page_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgW-1:0]      frames_in_use_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [PageInW-1:0]   page_number_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 hit_o;
  logic [SlotW-1:0]     frame_slot_o;
  logic                 evicted_valid_o;
  logic [PageInW-1:0]   evicted_page_o;
  logic [FaultW-1:0]    fault_total_o;

  // predictor copy of the frame table
  logic [PageInW-1:0]   frame_page_q[NumFrames];
  bit                   frame_valid_q[NumFrames];
  int unsigned          frame_rank_q[NumFrames];
  int unsigned          filled_frames;
  logic [FaultW-1:0]    fault_tally;
  logic [CfgW-1:0]      frames_setting;

  page_result_t         pending_results[$];
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          burst_left = 0;
  int unsigned          stall_left = 0;
  stall_mode_e          stall_mode = STALL_NONE;

  lru_page_replacement_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .frames_in_use_i (frames_in_use_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned active_frames();
    if (frames_setting == 0) return 1;
    if (frames_setting > NumFrames) return NumFrames;
    return 32'(frames_setting);
  endfunction

  function automatic void promote_frame(int unsigned f, bit was_valid);
    int unsigned r;
    if (was_valid) begin
      r = frame_rank_q[f];
      for (int unsigned i = 0; i < NumFrames; i++) begin
        if (frame_valid_q[i] && frame_rank_q[i] > r) frame_rank_q[i]--;
      end
      frame_rank_q[f] = filled_frames - 1;
    end else begin
      frame_rank_q[f] = filled_frames;
      frame_valid_q[f] = 1'b1;
      filled_frames++;
    end
  endfunction

  function automatic page_result_t predict_reference(logic [PageInW-1:0] pg);
    page_result_t res;
    int unsigned  n;
    int unsigned  slot;
    bit           found;
    n = active_frames();
    slot = 0;
    found = 1'b0;
    res.hit = 1'b0;
    res.evicted_valid = 1'b0;
    res.evicted_page = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!found && frame_valid_q[i] && frame_page_q[i] == pg) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      promote_frame(slot, 1'b1);
    end else begin
      if (fault_tally != '1) fault_tally++;
      for (int unsigned i = 0; i < n; i++) begin
        if (!found && !frame_valid_q[i]) begin
          found = 1'b1;
          slot = i;
        end
      end
      if (found) begin
        frame_page_q[slot] = pg;
        promote_frame(slot, 1'b0);
      end else begin
        slot = 0;
        for (int unsigned i = 1; i < n; i++) begin
          if (frame_rank_q[i] < frame_rank_q[slot]) slot = i;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page = frame_page_q[slot];
        frame_page_q[slot] = pg;
        promote_frame(slot, 1'b1);
      end
    end
    res.slot = slot[SlotW-1:0];
    res.faults = fault_tally;
    return res;
  endfunction

  task automatic send_page(input logic [PageInW-1:0] pg);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    page_number_i <= pg;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_reference(pg));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_frames(input logic [CfgW-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    frames_in_use_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    frames_setting = value;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // result checker, receiver stall pattern and cycle limit
  always @(posedge clk_i) begin
    page_result_t exp_r;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("lru_page_replacement_unit verification failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transaction, expected none actual slot %0d page %0h",
                 $time, frame_slot_o, evicted_page_o);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("hit", 32'(exp_r.hit), 32'(hit_o));
        check_field("frame_slot", 32'(exp_r.slot), 32'(frame_slot_o));
        check_field("evicted_valid", 32'(exp_r.evicted_valid), 32'(evicted_valid_o));
        check_field("evicted_page", 32'(exp_r.evicted_page), 32'(evicted_page_o));
        check_field("fault_total", exp_r.faults, fault_total_o);
      end
    end
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(16, 128);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 2) == 0);
      default:     out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic test_fill_and_evict();
    logic [PageInW-1:0] pages[$];
    set_frames(4'd8);
    pages = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
              16'h0005, 16'h0006, 16'h0000, 16'hFFFF, 16'h00AA, 16'h0004};
    foreach (pages[i]) send_page(pages[i]);
  endtask

  task automatic test_narrow_and_widen();
    set_frames(4'd2);
    send_page(16'h0003);
    send_page(16'h0000);
    set_frames(4'd8);
    send_page(16'h0003);
    send_page(16'h5555);
  endtask

  task automatic test_out_of_range_setting();
    set_frames(4'd0);
    send_page(16'hAAAA);
    send_page(16'hAAAA);
    set_frames(4'd15);
    send_page(16'h0001);
    send_page(16'h1234);
    set_frames(4'd9);
    send_page(16'h8000);
  endtask

  task automatic run_random_phase(input logic [CfgW-1:0] value, input int unsigned count);
    logic [PageInW-1:0] pool[12];
    int unsigned        n;
    int unsigned        sel;
    set_frames(value);
    n = active_frames();
    foreach (pool[j]) pool[j] = 16'($urandom_range(0, 65535));
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    for (int unsigned k = 0; k < count; k++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) send_page(16'($urandom_range(0, 65535)));
      else send_page(pool[$urandom_range(0, n + 3)]);
    end
  endtask

  task automatic test_random_traffic();
    logic [CfgW-1:0] settings[$];
    settings = '{4'd8, 4'd1, 4'd3, 4'd5, 4'd2, 4'd7, 4'd0, 4'd6, 4'd4, 4'd12, 4'd8};
    foreach (settings[i]) run_random_phase(settings[i], 180);
  endtask

  initial begin
    for (int unsigned i = 0; i < NumFrames; i++) begin
      frame_page_q[i] = '0;
      frame_valid_q[i] = 1'b0;
      frame_rank_q[i] = 0;
    end
    filled_frames = 0;
    fault_tally = '0;
    frames_setting = CfgReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_evict();
    test_narrow_and_widen();
    test_out_of_range_setting();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("lru_page_replacement_unit verification clean");
    end else begin
      $display("lru_page_replacement_unit verification failed");
    end
    $finish;
  end

endmodule
